// ----- src/rv32_subset_execute_unit_macros.svh -----
// Assertion macros shared by the execute unit's modules.
`ifndef RV32_SUBSET_EXECUTE_UNIT_MACROS_SVH
`define RV32_SUBSET_EXECUTE_UNIT_MACROS_SVH

// Combinational check, sampled on every clock while out of reset.
`define RVSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Check in the cycle after a trigger.
`define RVSE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- src/rv32se_pkg.sv -----
// Shared types and constants of the RV32 subset execute unit.
`default_nettype none

package rv32se_pkg;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,
    OP_SUB  = 5'd1,
    OP_AND  = 5'd2,
    OP_OR   = 5'd3,
    OP_XOR  = 5'd4,
    OP_SLT  = 5'd5,
    OP_SLL  = 5'd6,
    OP_SRA  = 5'd7,
    OP_ADDI = 5'd8,
    OP_ANDI = 5'd9,
    OP_ORI  = 5'd10,
    OP_XORI = 5'd11,
    OP_SLTI = 5'd12,
    OP_LW   = 5'd13,
    OP_LB   = 5'd14,
    OP_SW   = 5'd15,
    OP_SB   = 5'd16,
    OP_LUI  = 5'd17
  } op_t;

  typedef enum logic [2:0] {
    K_NONE,
    K_ALU,
    K_LW,
    K_LB,
    K_SW,
    K_SB
  } kind_t;

  typedef enum logic [3:0] {
    FN_ADD,
    FN_SUB,
    FN_AND,
    FN_OR,
    FN_XOR,
    FN_SLT,
    FN_SLL,
    FN_SRA,
    FN_PASS
  } alu_fn_t;

  // Decoded instruction as it sits in the queue.
  typedef struct packed {
    kind_t       kind;
    alu_fn_t     fn;
    logic        use_imm;
    logic        wr_reg;
    logic [4:0]  rd;
    logic [4:0]  ra;
    logic [4:0]  rb;
    logic [31:0] imm;
  } dec_t;

endpackage

`default_nettype wire

// ----- src/rv32_subset_execute_unit.sv -----
// Top level of the RV32 subset execute unit: front end, queue, back end.
//
//   channel   direction  handshake              payload
//   in_*      input      in_valid / in_ready    opcode, first_reg, src_reg_a, src_reg_b,
//                                               immediate
//   out_*     output     out_valid / out_ready  reg_write, reg_index, reg_value, mem_write
//
// Every request yields exactly one result, in order.
// Back end steps per request: ALU ops and lui take register read and execute,
// sw/sb add a memory step, lw/lb a memory step and a load return; the
// register-file read and byte-bank read are registered; one request in the back end at a time.
// After reset the byte memory is cleared one row of four banks per cycle,
// 2**(MEM_ADDR_BITS-2) rows (16384 at the default); in_ready stays low meanwhile.
// A two-deep queue decouples input from execution; a full result register
// that is not taken holds the back end, the front keeps filling the queue.
`default_nettype none

module rv32_subset_execute_unit #(
  parameter int MEM_ADDR_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [4:0]         in_opcode,
  input  wire logic [4:0]         in_first_reg,
  input  wire logic [4:0]         in_src_reg_a,
  input  wire logic [4:0]         in_src_reg_b,
  input  wire logic signed [31:0] in_immediate,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_reg_write,
  output logic [4:0]              out_reg_index,
  output logic signed [31:0]      out_reg_value,
  output logic                    out_mem_write
);

  // front -> queue
  logic              push;
  rv32se_pkg::dec_t  push_data;
  // queue -> back
  logic              q_full;
  logic              q_valid;
  rv32se_pkg::dec_t  q_head;
  // back -> queue / front
  logic              pop;
  logic              clear_busy;

  // Decode and accept; stalls only on a full queue or the memory clear
  rv32se_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_opcode    (in_opcode),
    .in_first_reg (in_first_reg),
    .in_src_reg_a (in_src_reg_a),
    .in_src_reg_b (in_src_reg_b),
    .in_immediate (in_immediate),
    .q_full       (q_full),
    .clear_busy   (clear_busy),
    .push         (push),
    .push_data    (push_data)
  );

  rv32se_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .valid     (q_valid),
    .head      (q_head)
  );

  // Register file, byte memory and result register live in the back end
  rv32se_back #(
    .MEM_ADDR_BITS (MEM_ADDR_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .pop           (pop),
    .clear_busy    (clear_busy),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_reg_write (out_reg_write),
    .out_reg_index (out_reg_index),
    .out_reg_value (out_reg_value),
    .out_mem_write (out_mem_write)
  );

endmodule

`default_nettype wire

// ----- src/rv32se_front.sv -----
// Front end: input handshake and instruction classification.
`default_nettype none

module rv32se_front (
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [4:0]         in_opcode,
  input  wire logic [4:0]         in_first_reg,
  input  wire logic [4:0]         in_src_reg_a,
  input  wire logic [4:0]         in_src_reg_b,
  input  wire logic signed [31:0] in_immediate,
  input  wire logic               q_full,
  input  wire logic               clear_busy,
  output logic                    push,
  output rv32se_pkg::dec_t        push_data
);

  logic [31:0] imm_u;
  logic [31:0] imm_i;

  assign in_ready = !q_full && !clear_busy;
  assign push     = in_valid && in_ready;
  assign imm_u    = in_immediate;
  assign imm_i    = {{20{imm_u[11]}}, imm_u[11:0]};

  always_comb begin
    push_data.kind    = rv32se_pkg::K_NONE;
    push_data.fn      = rv32se_pkg::FN_ADD;
    push_data.use_imm = 1'b0;
    push_data.rd      = in_first_reg;
    push_data.ra      = in_src_reg_a;
    push_data.rb      = in_src_reg_b;
    push_data.imm     = imm_i;
    unique case (rv32se_pkg::op_t'(in_opcode))
      rv32se_pkg::OP_ADD: begin
        push_data.kind = rv32se_pkg::K_ALU;
        push_data.fn   = rv32se_pkg::FN_ADD;
      end
      rv32se_pkg::OP_SUB: begin
        push_data.kind = rv32se_pkg::K_ALU;
        push_data.fn   = rv32se_pkg::FN_SUB;
      end
      rv32se_pkg::OP_AND: begin
        push_data.kind = rv32se_pkg::K_ALU;
        push_data.fn   = rv32se_pkg::FN_AND;
      end
      rv32se_pkg::OP_OR: begin
        push_data.kind = rv32se_pkg::K_ALU;
        push_data.fn   = rv32se_pkg::FN_OR;
      end
      rv32se_pkg::OP_XOR: begin
        push_data.kind = rv32se_pkg::K_ALU;
        push_data.fn   = rv32se_pkg::FN_XOR;
      end
      rv32se_pkg::OP_SLT: begin
        push_data.kind = rv32se_pkg::K_ALU;
        push_data.fn   = rv32se_pkg::FN_SLT;
      end
      rv32se_pkg::OP_SLL: begin
        push_data.kind = rv32se_pkg::K_ALU;
        push_data.fn   = rv32se_pkg::FN_SLL;
      end
      rv32se_pkg::OP_SRA: begin
        push_data.kind = rv32se_pkg::K_ALU;
        push_data.fn   = rv32se_pkg::FN_SRA;
      end
      rv32se_pkg::OP_ADDI: begin
        push_data.kind    = rv32se_pkg::K_ALU;
        push_data.fn      = rv32se_pkg::FN_ADD;
        push_data.use_imm = 1'b1;
      end
      rv32se_pkg::OP_ANDI: begin
        push_data.kind    = rv32se_pkg::K_ALU;
        push_data.fn      = rv32se_pkg::FN_AND;
        push_data.use_imm = 1'b1;
      end
      rv32se_pkg::OP_ORI: begin
        push_data.kind    = rv32se_pkg::K_ALU;
        push_data.fn      = rv32se_pkg::FN_OR;
        push_data.use_imm = 1'b1;
      end
      rv32se_pkg::OP_XORI: begin
        push_data.kind    = rv32se_pkg::K_ALU;
        push_data.fn      = rv32se_pkg::FN_XOR;
        push_data.use_imm = 1'b1;
      end
      rv32se_pkg::OP_SLTI: begin
        push_data.kind    = rv32se_pkg::K_ALU;
        push_data.fn      = rv32se_pkg::FN_SLT;
        push_data.use_imm = 1'b1;
      end
      rv32se_pkg::OP_LW: begin
        push_data.kind = rv32se_pkg::K_LW;
        push_data.imm  = imm_u;
      end
      rv32se_pkg::OP_LB: begin
        push_data.kind = rv32se_pkg::K_LB;
        push_data.imm  = imm_u;
      end
      rv32se_pkg::OP_SW: begin
        push_data.kind = rv32se_pkg::K_SW;
        push_data.rb   = in_first_reg;   // store data rides on read port B
        push_data.imm  = imm_u;
      end
      rv32se_pkg::OP_SB: begin
        push_data.kind = rv32se_pkg::K_SB;
        push_data.rb   = in_first_reg;
        push_data.imm  = imm_u;
      end
      rv32se_pkg::OP_LUI: begin
        push_data.kind    = rv32se_pkg::K_ALU;
        push_data.fn      = rv32se_pkg::FN_PASS;
        push_data.use_imm = 1'b1;
        push_data.imm     = {imm_u[19:0], 12'h000};
      end
      default: begin
        push_data.kind = rv32se_pkg::K_NONE;
      end
    endcase
    push_data.wr_reg = (push_data.kind == rv32se_pkg::K_ALU ||
                        push_data.kind == rv32se_pkg::K_LW ||
                        push_data.kind == rv32se_pkg::K_LB) && (in_first_reg != 5'd0);
  end

endmodule

`default_nettype wire

// ----- src/rv32se_queue.sv -----
// Small FIFO of decoded instructions between front and back end.
`include "rv32_subset_execute_unit_macros.svh"
`default_nettype none

module rv32se_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire rv32se_pkg::dec_t  push_data,
  input  wire logic              pop,
  output logic                   full,
  output logic                   valid,
  output rv32se_pkg::dec_t       head
);

  localparam int DEPTH = rv32se_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rv32se_pkg::dec_t  entry_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + {{(PTR_W-1){1'b0}}, 1'b1};
    end
    return r;
  endfunction

  assign full  = (count_r == CNT_W'(DEPTH));
  assign valid = (count_r != '0);
  assign head  = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + {{(CNT_W-1){1'b0}}, 1'b1};
      end else if (pop && !push) begin
        count_r <= count_r - {{(CNT_W-1){1'b0}}, 1'b1};
      end
    end
  end

  `RVSE_ASSERT(a_no_push_full, !(push && full && !pop), "queue push while full")
  `RVSE_ASSERT(a_no_pop_empty, !(pop && !valid), "queue pop while empty")

endmodule

`default_nettype wire

// ----- src/rv32se_back.sv -----
// Back end: register file, byte memory banks, execute sequencer, result register.
`include "rv32_subset_execute_unit_macros.svh"
`default_nettype none

module rv32se_back #(
  parameter int MEM_ADDR_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  input  wire rv32se_pkg::dec_t   q_head,
  output logic                    pop,
  output logic                    clear_busy,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_reg_write,
  output logic [4:0]              out_reg_index,
  output logic signed [31:0]      out_reg_value,
  output logic                    out_mem_write
);

  localparam int ROW_BITS = MEM_ADDR_BITS - 2;
  localparam int ROWS     = 1 << ROW_BITS;

  typedef enum logic [1:0] {
    S_READ,
    S_EXEC,
    S_MEM,
    S_LRET
  } state_t;

  state_t                   state_r;
  rv32se_pkg::dec_t         instr_r;
  logic [31:0]              rf_mem [32];
  logic [31:0]              rf_vld_r;
  logic [31:0]              rf_a_r;
  logic [31:0]              rf_b_r;
  logic                     rf_a_vld_r;
  logic                     rf_b_vld_r;
  logic [MEM_ADDR_BITS-1:0] addr_r;
  logic [31:0]              st_r;
  logic                     clear_busy_r;
  logic [ROW_BITS-1:0]      clr_row_r;
  logic                     out_valid_r;
  logic                     out_reg_write_r;
  logic [4:0]               out_reg_index_r;
  logic [31:0]              out_reg_value_r;
  logic                     out_mem_write_r;

  logic [31:0]              op_a;
  logic [31:0]              op_b;
  logic [31:0]              op_y;
  logic [31:0]              alu_res;
  logic [31:0]              ea;
  logic                     is_mem;
  logic                     is_load;
  logic                     is_store;
  logic                     out_free;
  logic                     produce;
  logic                     rf_we;
  logic [31:0]              wb_val;
  logic                     wb_mw;
  logic [1:0]               lane;
  logic [ROW_BITS-1:0]      row_base;
  logic [ROW_BITS-1:0]      row_next;
  logic [ROW_BITS-1:0]      bank_row [4];
  logic [7:0]               bank_wd  [4];
  logic [3:0]               bank_we;
  logic                     bank_re;
  logic [7:0]               bank_q   [4];
  logic [7:0]               ld_b     [4];
  logic [31:0]              ld_val;

  assign clear_busy    = clear_busy_r;
  assign pop           = (state_r == S_READ) && q_valid && !clear_busy_r;
  assign out_valid     = out_valid_r;
  assign out_reg_write = out_reg_write_r;
  assign out_reg_index = out_reg_index_r;
  assign out_reg_value = out_reg_value_r;
  assign out_mem_write = out_mem_write_r;

  // Operands; never-written registers and x0 read as zero
  assign op_a = rf_a_vld_r ? rf_a_r : '0;
  assign op_b = rf_b_vld_r ? rf_b_r : '0;
  assign op_y = instr_r.use_imm ? instr_r.imm : op_b;
  assign ea   = op_a + instr_r.imm;

  assign is_load  = (instr_r.kind == rv32se_pkg::K_LW) || (instr_r.kind == rv32se_pkg::K_LB);
  assign is_store = (instr_r.kind == rv32se_pkg::K_SW) || (instr_r.kind == rv32se_pkg::K_SB);
  assign is_mem   = is_load || is_store;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    unique case (instr_r.fn)
      rv32se_pkg::FN_ADD:  alu_res = op_a + op_y;
      rv32se_pkg::FN_SUB:  alu_res = op_a - op_y;
      rv32se_pkg::FN_AND:  alu_res = op_a & op_y;
      rv32se_pkg::FN_OR:   alu_res = op_a | op_y;
      rv32se_pkg::FN_XOR:  alu_res = op_a ^ op_y;
      rv32se_pkg::FN_SLT:  alu_res = {31'd0, ($signed(op_a) < $signed(op_y))};
      rv32se_pkg::FN_SLL:  alu_res = op_a << op_y[4:0];
      rv32se_pkg::FN_SRA:  alu_res = $unsigned($signed(op_a) >>> op_y[4:0]);
      rv32se_pkg::FN_PASS: alu_res = op_y;
      default:             alu_res = '0;
    endcase
  end

  // Byte lanes: byte i of a word lives in bank (addr + i) mod 4; banks below
  // the start lane take the following row (wraps at the top of memory).
  assign lane     = addr_r[1:0];
  assign row_base = addr_r[MEM_ADDR_BITS-1:2];
  assign row_next = row_base + {{(ROW_BITS-1){1'b0}}, 1'b1};
  assign bank_re  = (state_r == S_MEM) && is_load;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      logic [1:0] sel;
      sel = 2'(k) - lane;
      if (clear_busy_r) begin
        bank_row[k] = clr_row_r;
        bank_wd[k]  = 8'h00;
        bank_we[k]  = 1'b1;
      end else begin
        bank_row[k] = (2'(k) < lane) ? row_next : row_base;
        bank_wd[k]  = st_r[8*sel +: 8];
        bank_we[k]  = (state_r == S_MEM) && out_free &&
                      ((instr_r.kind == rv32se_pkg::K_SW) ||
                       ((instr_r.kind == rv32se_pkg::K_SB) && (lane == 2'(k))));
      end
      ld_b[k] = bank_q[2'(k) + lane];
    end
  end

  assign ld_val = (instr_r.kind == rv32se_pkg::K_LW) ?
                  {ld_b[3], ld_b[2], ld_b[1], ld_b[0]} :
                  {{24{ld_b[0][7]}}, ld_b[0]};

  always_comb begin
    produce = 1'b0;
    wb_val  = alu_res;
    wb_mw   = 1'b0;
    unique case (state_r)
      S_READ: produce = 1'b0;
      S_EXEC: produce = out_free && !is_mem;
      S_MEM: begin
        produce = out_free && is_store;
        wb_mw   = 1'b1;
      end
      S_LRET: begin
        produce = out_free;
        wb_val  = ld_val;
      end
      default: produce = 1'b0;
    endcase
  end

  assign rf_we = produce && instr_r.wr_reg;

  for (genvar g = 0; g < 4; g++) begin : g_bank
    logic [7:0] mem [ROWS];
    always_ff @(posedge clk) begin
      if (bank_we[g]) begin
        mem[bank_row[g]] <= bank_wd[g];
      end
      if (bank_re) begin
        bank_q[g] <= mem[bank_row[g]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rf_a_r <= rf_mem[q_head.ra];
      rf_b_r <= rf_mem[q_head.rb];
    end
    if (rf_we) begin
      rf_mem[instr_r.rd] <= wb_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_READ;
      rf_vld_r     <= '0;
      rf_a_vld_r   <= 1'b0;
      rf_b_vld_r   <= 1'b0;
      clear_busy_r <= 1'b1;
      clr_row_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (clear_busy_r) begin
        clr_row_r <= clr_row_r + {{(ROW_BITS-1){1'b0}}, 1'b1};
        if (&clr_row_r) begin
          clear_busy_r <= 1'b0;
        end
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (produce) begin
        out_valid_r     <= 1'b1;
        out_reg_write_r <= instr_r.wr_reg;
        out_reg_index_r <= instr_r.wr_reg ? instr_r.rd : 5'd0;
        out_reg_value_r <= instr_r.wr_reg ? wb_val : 32'd0;
        out_mem_write_r <= wb_mw;
      end
      if (rf_we) begin
        rf_vld_r[instr_r.rd] <= 1'b1;
      end
      unique case (state_r)
        S_READ: begin
          if (pop) begin
            instr_r    <= q_head;
            rf_a_vld_r <= rf_vld_r[q_head.ra];
            rf_b_vld_r <= rf_vld_r[q_head.rb];
            state_r    <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (is_mem) begin
            addr_r  <= ea[MEM_ADDR_BITS-1:0];
            st_r    <= op_b;
            state_r <= S_MEM;
          end else if (produce) begin
            state_r <= S_READ;
          end
        end
        S_MEM: begin
          if (is_load) begin
            state_r <= S_LRET;
          end else if (produce) begin
            state_r <= S_READ;
          end
        end
        S_LRET: begin
          if (produce) begin
            state_r <= S_READ;
          end
        end
        default: state_r <= S_READ;
      endcase
    end
  end

  `RVSE_ASSERT(a_x0_never_written, !(out_valid_r && out_reg_write_r && out_reg_index_r == 5'd0), "result claims a write to x0")
  `RVSE_ASSERT(a_reg_mem_exclusive, !(out_valid_r && out_reg_write_r && out_mem_write_r), "register and memory write in one result")
  `RVSE_ASSERT_NEXT(a_no_issue_in_clear, clear_busy_r, (state_r == S_READ) || !clear_busy_r, "instruction issued during memory clear")

endmodule

`default_nettype wire
